// ----- hdl/tlvcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV change suppressor package
// Beat types and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package tlvcs_pkg;

    // Number of distinct type byte codes.
    localparam int TYPE_CODES = 256;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       force_all;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        record_end;
        logic        packet_end;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // take the input beat and issue the store reads
        logic exec;         // run one parse step on the captured byte
        logic load_marker;  // load the end marker into the output register
        logic emit_read;    // read the next record byte from the value store
        logic emit_pack;    // pack the record byte into the word being built
        logic flush;        // move the built word into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_marker;    // captured byte is the end marker
        logic emit_req;     // this parse step completes a changed record
        logic word_done;    // the byte being packed completes a word
        logic rec_last;     // every byte of the record has been packed
        logic out_ready;    // output register can take a beat this cycle
    } t_sts;

endpackage

// ----- hdl/tlvcs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV change suppressor controller
// Sequences capture, parse step and record read-back over the datapath.
// ----------------------------------------------------------------------------
module tlvcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  tlvcs_pkg::t_sts i_sts,
    output tlvcs_pkg::t_cmd o_cmd
);
    import tlvcs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_PK   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_stall = !i_rst_n || (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && !o_stall) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.is_marker) begin
                    // The marker waits here until the output register frees up.
                    if (i_sts.out_ready) begin
                        o_cmd.load_marker = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.emit_req ? ST_RD : ST_IDLE;
                end
            end
            ST_RD: begin
                o_cmd.emit_read = 1'b1;
                n_state         = ST_PK;
            end
            ST_PK: begin
                o_cmd.emit_pack = 1'b1;
                n_state         = i_sts.word_done ? ST_OUT : ST_RD;
            end
            ST_OUT: begin
                if (i_sts.out_ready) begin
                    o_cmd.flush = 1'b1;
                    n_state     = i_sts.rec_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("controller issued more than one command");
`endif

endmodule

// ----- hdl/tlvcs_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV change suppressor datapath
// Parse registers, length and value stores, word packer and output register.
// ----------------------------------------------------------------------------
module tlvcs_dpath #(
    parameter int TYPE_COUNT     = 256,
    parameter int VALUE_BYTES    = 256,
    parameter int OUT_WORD_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlvcs_pkg::t_cmd      i_cmd,
    output tlvcs_pkg::t_sts      o_sts,
    input  tlvcs_pkg::t_in_beat  i_data,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output tlvcs_pkg::t_out_beat o_data
);
    import tlvcs_pkg::*;

    localparam int SLOT_W    = $clog2(TYPE_COUNT);
    localparam int VAL_DEPTH = TYPE_COUNT * VALUE_BYTES;
    localparam int VAL_AW    = $clog2(VAL_DEPTH);
    localparam int IDX_W     = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;

    localparam logic [1:0] PH_TYPE   = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;

    // Type byte to store slot, worked out at elaboration.
    logic [SLOT_W-1:0] w_slot_lut [TYPE_CODES];
    for (genvar g = 0; g < TYPE_CODES; g++) begin : g_slot_lut
        assign w_slot_lut[g] = SLOT_W'(g % TYPE_COUNT);
    end

    logic [7:0]            r_end_code;
    logic [7:0]            r_byte;
    logic                  r_force;
    logic [1:0]            r_phase;
    logic [7:0]            r_cur_type;
    logic [7:0]            r_cur_len;
    logic [7:0]            r_vidx;
    logic                  r_changed;
    logic [SLOT_W-1:0]     r_slot;
    logic [VAL_AW-1:0]     r_base;
    logic [7:0]            r_len_mem [TYPE_COUNT];
    logic [TYPE_COUNT-1:0] r_len_vld;
    logic [7:0]            r_len_rd;
    logic                  r_len_vld_rd;
    logic [7:0]            r_val_mem [VAL_DEPTH];
    logic [7:0]            r_val_rd;
    logic [8:0]            r_k;
    logic [3:0]            r_cnt;
    logic [63:0]           r_word;
    logic [63:0]           n_word;
    logic                  r_out_valid;
    t_out_beat             r_out;

    logic              w_is_marker;
    logic [7:0]        w_len_old;
    logic              w_vidx_in;
    logic [7:0]        w_vidx_inc;
    logic              w_chg_len;
    logic              w_chg_val;
    logic              w_emit_req;
    logic [8:0]        w_total;
    logic [8:0]        w_kidx;
    logic              w_k_in;
    logic [8:0]        w_k_inc;
    logic [3:0]        w_cnt_inc;
    logic [7:0]        w_emit_byte;
    logic              w_word_done;
    logic [VAL_AW-1:0] w_rd_addr;
    logic [VAL_AW-1:0] w_wr_addr;
    logic              w_out_ready;
    logic [SLOT_W-1:0] w_new_slot;

    assign w_is_marker = (r_phase == PH_TYPE) && (r_byte == r_end_code);
    assign w_len_old   = r_len_vld_rd ? r_len_rd : 8'd0;
    assign w_vidx_in   = {1'b0, r_vidx} < 9'(VALUE_BYTES);
    assign w_vidx_inc  = r_vidx + 8'd1;
    assign w_chg_len   = r_force || (w_len_old != r_byte);
    assign w_chg_val   = !w_vidx_in || r_changed || (r_val_rd != r_byte);

    always_comb begin
        unique case (r_phase)
            PH_LENGTH: w_emit_req = (r_byte == 8'd0) && w_chg_len;
            PH_VALUE:  w_emit_req = (w_vidx_inc == r_cur_len) && w_chg_val;
            default:   w_emit_req = 1'b0;
        endcase
    end

    assign w_total   = {1'b0, r_cur_len} + 9'd2;
    assign w_kidx    = r_k - 9'd2;
    assign w_k_in    = w_kidx < 9'(VALUE_BYTES);
    assign w_k_inc   = r_k + 9'd1;
    assign w_cnt_inc = r_cnt + 4'd1;

    always_comb begin
        priority if (r_k == 9'd0) begin
            w_emit_byte = r_cur_type;
        end else if (r_k == 9'd1) begin
            w_emit_byte = r_cur_len;
        end else if (w_k_in) begin
            w_emit_byte = r_val_rd;
        end else begin
            w_emit_byte = 8'd0;
        end
    end

    assign w_word_done = (w_cnt_inc == 4'(OUT_WORD_BYTES)) || (w_k_inc == w_total);

    assign w_rd_addr = r_base + (i_cmd.emit_read ? VAL_AW'(w_kidx[IDX_W-1:0])
                                                 : VAL_AW'(r_vidx[IDX_W-1:0]));
    assign w_wr_addr = r_base + VAL_AW'(r_vidx[IDX_W-1:0]);

    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_new_slot  = w_slot_lut[r_byte];

    assign o_sts.is_marker = w_is_marker;
    assign o_sts.emit_req  = w_emit_req;
    assign o_sts.word_done = w_word_done;
    assign o_sts.rec_last  = (r_k == w_total);
    assign o_sts.out_ready = w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_code <= 8'd0;
        end else if (i_cfg_wr_en) begin
            r_end_code <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte  <= i_data.data_byte;
            r_force <= i_data.force_all;
        end
    end

    // Length store: read on capture, written by the length parse step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_len_rd     <= r_len_mem[r_slot];
            r_len_vld_rd <= r_len_vld[r_slot];
        end
        if (i_cmd.exec && (r_phase == PH_LENGTH)) begin
            r_len_mem[r_slot] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
        end else if (i_cmd.exec && (r_phase == PH_LENGTH)) begin
            r_len_vld[r_slot] <= 1'b1;
        end
    end

    // Value store: one read port shared by compare and read-back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture || i_cmd.emit_read) begin
            r_val_rd <= r_val_mem[w_rd_addr];
        end
        if (i_cmd.exec && (r_phase == PH_VALUE) && w_vidx_in) begin
            r_val_mem[w_wr_addr] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TYPE;
            r_cur_type <= 8'd0;
            r_cur_len  <= 8'd0;
            r_vidx     <= 8'd0;
            r_changed  <= 1'b0;
            r_slot     <= '0;
            r_base     <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_phase)
                PH_TYPE: begin
                    r_cur_type <= r_byte;
                    r_slot     <= w_new_slot;
                    r_base     <= VAL_AW'(w_new_slot) * VAL_AW'(VALUE_BYTES);
                    r_phase    <= PH_LENGTH;
                end
                PH_LENGTH: begin
                    r_cur_len <= r_byte;
                    r_vidx    <= 8'd0;
                    r_changed <= w_chg_len;
                    r_phase   <= (r_byte == 8'd0) ? PH_TYPE : PH_VALUE;
                end
                PH_VALUE: begin
                    r_changed <= w_chg_val;
                    r_vidx    <= w_vidx_inc;
                    if (w_vidx_inc == r_cur_len) begin
                        r_phase <= PH_TYPE;
                    end
                end
                default: begin
                    r_phase <= PH_TYPE;
                end
            endcase
        end
    end

    always_comb begin
        n_word = r_word;
        for (int l = 0; l < 8; l++) begin
            if (r_cnt[2:0] == 3'(l)) begin
                n_word[8*l +: 8] = w_emit_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= 9'd0;
            r_cnt  <= 4'd0;
            r_word <= 64'd0;
        end else if (i_cmd.exec) begin
            r_k    <= 9'd0;
            r_cnt  <= 4'd0;
            r_word <= 64'd0;
        end else if (i_cmd.emit_pack) begin
            r_word <= n_word;
            r_cnt  <= w_cnt_inc;
            r_k    <= w_k_inc;
        end else if (i_cmd.flush) begin
            r_cnt  <= 4'd0;
            r_word <= 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_marker || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_marker) begin
            r_out.out_bytes  <= 64'(r_byte);
            r_out.byte_count <= 4'd1;
            r_out.record_end <= 1'b1;
            r_out.packet_end <= 1'b1;
        end else if (i_cmd.flush) begin
            r_out.out_bytes  <= r_word;
            r_out.byte_count <= r_cnt;
            r_out.record_end <= (r_k == w_total);
            r_out.packet_end <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_marker || i_cmd.flush) |-> w_out_ready)
        else $error("output register loaded while a beat was still held");

    a_word_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(OUT_WORD_BYTES))
        else $error("word packer overfilled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.byte_count != 4'd0)
                        && (r_out.byte_count <= 4'(OUT_WORD_BYTES)))
        else $error("output byte count out of range");

    a_marker_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.packet_end) |-> (r_out.record_end
                                                && (r_out.byte_count == 4'd1)))
        else $error("end marker beat malformed");
`endif

endmodule

// ----- hdl/tlv_change_suppressor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV change suppressor
// Filters a byte stream of type-length-value records, passing on only the
// records forced or changed in length or value since the type was last seen.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ----------------------  ------------------------------
//  input     in         i_valid / o_stall       i_data  (data_byte, force_all)
//  output    out        o_valid / i_stall       o_data  (out_bytes, byte_count,
//                                                        record_end, packet_end)
//  config    in         i_cfg_wr_en             i_cfg_wr_data (end_code)
//
// Each input beat is first captured, which issues the store reads, and then
// compared against the registered read data in a step that updates the store.
// When a beat completes a changed record, the record is read back one byte
// at a time through the single read port of the byte-wide value store, with
// a read state and a pack state per byte and an output state per word,
// before the next beat is taken.
// Reset is synchronous and clears the parse state and the per-type length
// valid bits; there is no clearing pass. Value bytes are only read after
// they were written.
// Results leave through an output register, so a stalled output only holds
// the block when a new beat must be loaded while the previous one waits.
//
module tlv_change_suppressor_unit #(
    parameter int TYPE_COUNT     = 256,
    parameter int VALUE_BYTES    = 256,
    parameter int OUT_WORD_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  tlvcs_pkg::t_in_beat  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output tlvcs_pkg::t_out_beat o_data,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data
);
    import tlvcs_pkg::*;

    // Command and status between the sequencer and the datapath.
    t_cmd w_cmd;
    t_sts w_sts;

    // The controller owns the input handshake and all sequencing.
    tlvcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the stores, parse registers and output register.
    tlvcs_dpath #(
        .TYPE_COUNT     (TYPE_COUNT),
        .VALUE_BYTES    (VALUE_BYTES),
        .OUT_WORD_BYTES (OUT_WORD_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_data        (i_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data        (o_data)
    );

endmodule
